@@ src/idws_pkg.sv @@
package idws_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_GET        = 3'd4,
        OP_SET        = 3'd5,
        OP_CLEAR      = 3'd6,
        OP_SORT       = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SORT_I,
        S_SORT_KEY,
        S_SORT_CMP,
        S_SORT_INS
    } t_state;

    typedef struct packed {
        t_op         opcode;
        logic [31:0] value;
        logic [3:0]  position;
    } t_cmd;

    typedef struct packed {
        logic [31:0] read_data;
        t_status     status;
        logic [4:0]  count;
    } t_result;

endpackage

@@ src/indexed_deque_with_sort.sv @@
// Bounded double-ended queue in a ring memory with one read and one write
// port, and one comparator. A command is taken when start is high and
// busy is low; its one result appears on o_result for exactly one cycle,
// flagged by o_valid, and must be captured then since it cannot be held off.
// Push, pop, get, set and clear pass through the execute state to a registered
// result, and the next start is taken in the cycle the result is shown. Sort
// runs an insertion sort through the one memory read port and the comparator,
// stepping each element through the sort states before the execute state. The
// ring memory is not cleared; only written entries ever reach a result.
module indexed_deque_with_sort (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  idws_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    output idws_pkg::t_result o_result
);
    import idws_pkg::*;

    t_state r_state, n_state;

    t_op                   r_op, n_op;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [3:0]            r_pos, n_pos;
    logic [PTR_W-1:0]      r_front, n_front;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [CNT_W-1:0]      r_i, n_i;
    logic [CNT_W-1:0]      r_j, n_j;
    logic [DATA_WIDTH-1:0] r_key, n_key;
    logic                  r_valid, n_valid;
    t_result               r_out, n_out;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [PTR_W-1:0]      mem_raddr;
    logic [PTR_W-1:0]      mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_we;

    logic                  w_gt;
    logic                  w_full;
    logic                  w_in_range;

    function automatic logic [PTR_W-1:0] f_slot(input logic [PTR_W-1:0] front,
                                               input logic [CNT_W-1:0] logical);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(front) + (CNT_W+1)'(logical);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return PTR_W'(sum);
    endfunction

    assign w_gt       = r_rdata > r_key;
    assign w_full     = 32'(r_cnt) >= DEPTH;
    assign w_in_range = 32'(r_pos) < 32'(r_cnt);

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (i_cmd.opcode == OP_SORT) ? S_SORT_I : S_EXEC;
                end
            end
            S_EXEC:     n_state = S_IDLE;
            S_SORT_I:   n_state = (r_i >= r_cnt) ? S_EXEC : S_SORT_KEY;
            S_SORT_KEY: n_state = S_SORT_CMP;
            S_SORT_CMP: begin
                if (w_gt) begin
                    n_state = (r_j == CNT_W'(1)) ? S_SORT_INS : S_SORT_CMP;
                end else begin
                    n_state = S_SORT_I;
                end
            end
            S_SORT_INS: n_state = S_SORT_I;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_op      = r_op;
        n_val     = r_val;
        n_pos     = r_pos;
        n_front   = r_front;
        n_cnt     = r_cnt;
        n_i       = r_i;
        n_j       = r_j;
        n_key     = r_key;
        n_valid   = 1'b0;
        n_out     = r_out;
        mem_we    = 1'b0;
        mem_waddr = f_slot(r_front, r_j);
        mem_wdata = r_key;
        mem_raddr = f_slot(r_front, r_i);

        unique case (r_state)
            S_IDLE: begin
                // read for get goes out with the transfer
                mem_raddr = f_slot(r_front, CNT_W'(i_cmd.position));
                if (start) begin
                    n_op  = i_cmd.opcode;
                    n_val = DATA_WIDTH'(i_cmd.value);
                    n_pos = i_cmd.position;
                    n_i   = CNT_W'(1);
                end
            end
            S_EXEC: begin
                n_out.read_data = '0;
                n_out.status    = ST_OK;
                unique case (r_op)
                    OP_PUSH_BACK: begin
                        if (w_full) begin
                            n_out.status = ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = f_slot(r_front, r_cnt);
                            mem_wdata = r_val;
                            n_cnt     = r_cnt + CNT_W'(1);
                        end
                    end
                    OP_PUSH_FRONT: begin
                        if (w_full) begin
                            n_out.status = ST_FULL;
                        end else begin
                            n_front   = (r_front == '0) ? PTR_W'(DEPTH - 1)
                                                        : r_front - PTR_W'(1);
                            mem_we    = 1'b1;
                            mem_waddr = n_front;
                            mem_wdata = r_val;
                            n_cnt     = r_cnt + CNT_W'(1);
                        end
                    end
                    OP_POP_BACK: begin
                        if (r_cnt == '0) begin
                            n_out.status = ST_EMPTY;
                        end else begin
                            n_cnt = r_cnt - CNT_W'(1);
                        end
                    end
                    OP_POP_FRONT: begin
                        if (r_cnt == '0) begin
                            n_out.status = ST_EMPTY;
                        end else begin
                            n_front = f_slot(r_front, CNT_W'(1));
                            n_cnt   = r_cnt - CNT_W'(1);
                        end
                    end
                    OP_GET: begin
                        if (w_in_range) begin
                            n_out.read_data = 32'(r_rdata);
                        end else begin
                            n_out.status = ST_RANGE;
                        end
                    end
                    OP_SET: begin
                        if (w_in_range) begin
                            mem_we    = 1'b1;
                            mem_waddr = f_slot(r_front, CNT_W'(r_pos));
                            mem_wdata = r_val;
                        end else begin
                            n_out.status = ST_RANGE;
                        end
                    end
                    OP_CLEAR: begin
                        n_cnt   = '0;
                        n_front = '0;
                    end
                    OP_SORT: begin
                    end
                    default: begin
                    end
                endcase
                n_out.count = 5'(n_cnt);
                n_valid     = 1'b1;
            end
            S_SORT_I: begin
                mem_raddr = f_slot(r_front, r_i);
                n_j       = r_i;
            end
            S_SORT_KEY: begin
                n_key     = r_rdata;
                mem_raddr = f_slot(r_front, r_j - CNT_W'(1));
            end
            S_SORT_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = f_slot(r_front, r_j);
                if (w_gt) begin
                    // shift the larger element up, fetch the next one down
                    mem_wdata = r_rdata;
                    n_j       = r_j - CNT_W'(1);
                    mem_raddr = f_slot(r_front, r_j - CNT_W'(2));
                end else begin
                    mem_wdata = r_key;
                    n_i       = r_i + CNT_W'(1);
                end
            end
            S_SORT_INS: begin
                mem_we    = 1'b1;
                mem_waddr = f_slot(r_front, r_j);
                mem_wdata = r_key;
                n_i       = r_i + CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_val <= n_val;
        r_pos <= n_pos;
        r_i   <= n_i;
        r_j   <= n_j;
        r_key <= n_key;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

`ifndef SYNTHESIS
    a_valid_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EXEC))
        else $error("result strobe without an execute cycle");

    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= DEPTH)
        else $error("element count above depth");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not raise busy");

    a_sort_j_le_i: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SORT_KEY || r_state == S_SORT_CMP || r_state == S_SORT_INS)
            |-> (r_j <= r_i))
        else $error("sort inner index past outer index");
`endif

endmodule

@@ tb/sv/tb_indexed_deque_with_sort.sv @@
`timescale 1ns / 100ps

module tb_indexed_deque_with_sort;
    import idws_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int ITEMS_PER_PH = 360;
    localparam int BLOCK_LEN    = 30;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    class deque_scoreboard;
        logic [DATA_WIDTH-1:0] ring [DEPTH];
        logic [PTR_W-1:0]      front;
        logic [CNT_W-1:0]      held;
        t_result               pending_results[$];
        int unsigned           mismatches;

        function new();
            foreach (ring[i]) ring[i] = '0;
            front      = '0;
            held       = '0;
            mismatches = 0;
        endfunction

        function logic [PTR_W-1:0] slot(int unsigned idx);
            return PTR_W'((front + idx) % DEPTH);
        endfunction

        // Predict the result of an accepted command and queue it.
        function void apply_cmd(t_cmd c);
            t_result               r;
            logic [DATA_WIDTH-1:0] vals [DEPTH];
            logic [DATA_WIDTH-1:0] key;
            int                    j;
            r.read_data = '0;
            r.status    = ST_OK;
            case (c.opcode)
                OP_PUSH_BACK: begin
                    if (held >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        ring[slot(held)] = c.value;
                        held++;
                    end
                end
                OP_PUSH_FRONT: begin
                    if (held >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        front = PTR_W'((front + DEPTH - 1) % DEPTH);
                        ring[front] = c.value;
                        held++;
                    end
                end
                OP_POP_BACK: begin
                    if (held == 0) r.status = ST_EMPTY;
                    else held--;
                end
                OP_POP_FRONT: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        front = PTR_W'((front + 1) % DEPTH);
                        held--;
                    end
                end
                OP_GET: begin
                    if (c.position >= held) r.status = ST_RANGE;
                    else r.read_data = ring[slot(c.position)];
                end
                OP_SET: begin
                    if (c.position >= held) r.status = ST_RANGE;
                    else ring[slot(c.position)] = c.value;
                end
                OP_CLEAR: begin
                    held  = '0;
                    front = '0;
                end
                default: begin
                    // sort held elements ascending, front to back
                    for (int i = 0; i < held; i++) vals[i] = ring[slot(i)];
                    for (int i = 1; i < held; i++) begin
                        key = vals[i];
                        j   = i;
                        while (j > 0 && vals[j-1] > key) begin
                            vals[j] = vals[j-1];
                            j--;
                        end
                        vals[j] = key;
                    end
                    for (int i = 0; i < held; i++) ring[slot(i)] = vals[i];
                end
            endcase
            r.count = held;
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result data=%h status=%0d count=%0d",
                             got.read_data, got.status, got.count);
            end else begin
                exp = pending_results[0];
                pending_results.delete(0);
                if (got.read_data !== exp.read_data || got.status !== exp.status ||
                    got.count !== exp.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: result mismatch exp data=%h status=%0d ",
                                  "count=%0d, got data=%h status=%0d count=%0d"},
                                 exp.read_data, exp.status, exp.count,
                                 got.read_data, got.status, got.count);
                end
            end
        endfunction
    endclass

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_cmd    i_cmd;
    logic    o_valid;
    t_result o_result;

    deque_scoreboard sb;

    indexed_deque_with_sort u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_result);
    end

    function automatic t_cmd cmd_of(t_op op, logic [31:0] v, logic [3:0] p);
        t_cmd c;
        c.opcode   = op;
        c.value    = v;
        c.position = p;
        return c;
    endfunction

    // Weight the opcodes so that fill phases reach full and drain phases reach empty.
    function automatic t_cmd random_cmd(int mode);
        int          w [8];
        int          total;
        int          r;
        int          k;
        logic [31:0] v;
        logic [3:0]  p;
        case (mode)
            MODE_FILL:  w = '{30, 30, 5, 5, 12, 12, 4, 2};
            MODE_DRAIN: w = '{8, 8, 28, 28, 12, 10, 4, 2};
            default:    w = '{14, 14, 14, 14, 16, 16, 8, 4};
        endcase
        total = 0;
        foreach (w[i]) total += w[i];
        r = $urandom_range(0, total - 1);
        k = 0;
        while (r >= w[k]) begin
            r -= w[k];
            k++;
        end
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2, 3:    v = $urandom_range(0, 7);
            default: v = $urandom;
        endcase
        if (sb.held != 0 && $urandom_range(0, 9) < 7)
            p = 4'($urandom_range(0, sb.held - 1));
        else
            p = 4'($urandom_range(0, 15));
        return cmd_of(t_op'(k), v, p);
    endfunction

    task automatic send_cmd(input t_cmd c, input int idle_pct);
        logic [$bits(t_cmd)-1:0] junk;
        // keep idling before the transfer while a roll of 0..99 is below idle_pct
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            junk  = $bits(t_cmd)'({$urandom, $urandom});
            start <= 1'b0;
            i_cmd <= t_cmd'(junk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.apply_cmd(c);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int idle_pct;
        sb      = new();
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue corner cases, then pushes at both ends, get, set, sort and range checks on a short queue
        send_cmd(cmd_of(OP_SORT,       32'h0,        4'd0),  16);
        send_cmd(cmd_of(OP_POP_BACK,   32'h0,        4'd0),  16);
        send_cmd(cmd_of(OP_POP_FRONT,  32'h0,        4'd0),  16);
        send_cmd(cmd_of(OP_GET,        32'h0,        4'd0),  16);
        send_cmd(cmd_of(OP_SET,        32'hFFFFFFFF, 4'd15), 16);
        send_cmd(cmd_of(OP_CLEAR,      32'h0,        4'd0),  16);
        send_cmd(cmd_of(OP_PUSH_BACK,  32'h0,        4'd0),  16);
        send_cmd(cmd_of(OP_PUSH_BACK,  32'hFFFFFFFF, 4'd15), 16);
        send_cmd(cmd_of(OP_PUSH_FRONT, 32'h80000000, 4'd0),  16);
        send_cmd(cmd_of(OP_PUSH_FRONT, 32'h00000001, 4'd0),  16);
        send_cmd(cmd_of(OP_PUSH_BACK,  32'h55555555, 4'd0),  16);
        for (int i = 0; i < 6; i++)
            send_cmd(cmd_of(OP_GET, 32'h0, 4'(i)), 16);
        send_cmd(cmd_of(OP_SET,        32'hAAAAAAAA, 4'd4),  16);
        send_cmd(cmd_of(OP_GET,        32'h0,        4'd15), 16);
        send_cmd(cmd_of(OP_SORT,       32'h0,        4'd0),  16);
        send_cmd(cmd_of(OP_GET,        32'h0,        4'd0),  16);
        send_cmd(cmd_of(OP_GET,        32'h0,        4'd4),  16);
        send_cmd(cmd_of(OP_POP_FRONT,  32'h0,        4'd0),  16);
        send_cmd(cmd_of(OP_POP_BACK,   32'h0,        4'd0),  16);
        send_cmd(cmd_of(OP_CLEAR,      32'h0,        4'd0),  16);
        send_cmd(cmd_of(OP_GET,        32'h0,        4'd0),  16);

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 16 : (ph == 1) ? 83 : 0;
            for (int b = 0; b < ITEMS_PER_PH / BLOCK_LEN; b++) begin
                int mode;
                mode = $urandom_range(MODE_FILL, MODE_MIXED);
                for (int n = 0; n < BLOCK_LEN; n++)
                    send_cmd(random_cmd(mode), idle_pct);
            end
            // hold off until every expected result is in
            if (ph == 0) drain_results();
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ indexed_deque_with_sort.f @@
src/idws_pkg.sv
src/indexed_deque_with_sort.sv
tb/sv/tb_indexed_deque_with_sort.sv
